>>> hdl/csod_pkg.sv
`default_nettype none

package csod_pkg;

	localparam logic [3:0] OPC_SETCL   = 4'd0;
	localparam logic [3:0] OPC_INCR    = 4'd1;
	localparam logic [3:0] OPC_NONINCR = 4'd2;
	localparam logic [3:0] OPC_MASK    = 4'd3;
	localparam logic [3:0] OPC_IMM     = 4'd4;
	localparam logic [3:0] OPC_RESTART = 4'd5;
	localparam logic [3:0] OPC_GATHER  = 4'd6;
	localparam logic [3:0] OPC_EXTEND  = 4'd14;
	localparam logic [3:0] OPC_CHDONE  = 4'd15;

	localparam logic [1:0] GATHER_PLAIN   = 2'd0;
	localparam logic [1:0] GATHER_NONINCR = 2'd1;
	localparam logic [1:0] GATHER_INCR    = 2'd2;

	typedef enum logic [2:0] {
		MODE_HEADER = 3'd0,
		MODE_COUNT  = 3'd1,
		MODE_MASKED = 3'd2,
		MODE_GBASE  = 3'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_WRITE   = 2'd1,
		KIND_GBASE   = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	typedef struct packed {
		mode_t       mode;
		logic [11:0] reg_pointer;
		logic [15:0] words_left;
		logic [15:0] mask_left;
		logic [3:0]  owner_opcode;
	} state_t;

	typedef struct packed {
		kind_t       record_kind;
		logic [3:0]  opcode;
		logic [11:0] reg_offset;
		logic [9:0]  class_id;
		logic [15:0] word_count;
		logic [15:0] write_mask;
		logic [31:0] data_value;
		logic [1:0]  gather_mode;
		logic [3:0]  extend_subop;
	} record_t;

endpackage

`default_nettype wire

>>> hdl/csod_cmd_if.sv
`default_nettype none

interface csod_cmd_if;
	logic        valid;
	logic        ready;
	logic [31:0] command_word;
	logic        buffer_start;

	modport source (output valid, command_word, buffer_start, input ready);
	modport sink (input valid, command_word, buffer_start, output ready);
endinterface

`default_nettype wire

>>> hdl/csod_rec_if.sv
`default_nettype none

interface csod_rec_if;
	logic        valid;
	logic        ready;
	logic [1:0]  record_kind;
	logic [3:0]  opcode;
	logic [11:0] reg_offset;
	logic [9:0]  class_id;
	logic [15:0] word_count;
	logic [15:0] write_mask;
	logic [31:0] data_value;
	logic [1:0]  gather_mode;
	logic [3:0]  extend_subop;

	modport source (
		output valid, record_kind, opcode, reg_offset, class_id, word_count,
			write_mask, data_value, gather_mode, extend_subop,
		input ready
	);
	modport sink (
		input valid, record_kind, opcode, reg_offset, class_id, word_count,
			write_mask, data_value, gather_mode, extend_subop,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/command_stream_opcode_decoder.sv
// Command stream opcode decoder.
// cmd (sink): one 32-bit command word per handshake, with buffer_start set on
// the first word of a buffer; that word is always decoded as a header and any
// pending payload is dropped.
// rec (source): exactly one decode record per accepted word, in order:
// header fields, register write with its target offset, gather base word, or
// an unknown-opcode marker.
// Throughput: one word per cycle. The word sits in an input register, the
// decode and payload counters form one combinational pass, and the record is
// held in an output register.
// When rec stalls, the output register holds its record, the input register
// still takes one more word, and then cmd.ready drops until rec drains.
// Reset clears the valid flags and the parser state, so the first word after
// reset is decoded as a header.
`default_nettype none

module command_stream_opcode_decoder (
	input  logic          clk,
	input  logic          arst_n,
	csod_cmd_if.sink      cmd,
	csod_rec_if.source    rec
);
	import csod_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        start_s1;
	logic        valid_s2;
	record_t     rec_s2;
	state_t      state_q;
	state_t      state_next;
	record_t     record;
	logic        advance;
	logic        take;

	assign advance   = valid_s1 && (!valid_s2 || rec.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign take      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1  <= cmd.command_word;
			start_s1 <= cmd.buffer_start;
		end
	end

	csod_decode u_decode (
		.state        (state_q),
		.command_word (word_s1),
		.buffer_start (start_s1),
		.record       (record),
		.state_next   (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q  <= state_next;
				valid_s2 <= 1'b1;
			end else if (rec.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rec_s2 <= record;
		end
	end

	assign rec.valid        = valid_s2;
	assign rec.record_kind  = rec_s2.record_kind;
	assign rec.opcode       = rec_s2.opcode;
	assign rec.reg_offset   = rec_s2.reg_offset;
	assign rec.class_id     = rec_s2.class_id;
	assign rec.word_count   = rec_s2.word_count;
	assign rec.write_mask   = rec_s2.write_mask;
	assign rec.data_value   = rec_s2.data_value;
	assign rec.gather_mode  = rec_s2.gather_mode;
	assign rec.extend_subop = rec_s2.extend_subop;

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_COUNT |-> state_q.words_left != 16'd0)
		else $error("counted payload with no words left");

	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_MASKED |-> state_q.mask_left != 16'd0)
		else $error("masked payload with empty mask");

	a_gather_base: assert property (@(posedge clk) disable iff (!arst_n)
		advance && record.record_kind == KIND_HEADER && record.opcode == OPC_GATHER
		|=> state_q.mode == MODE_GBASE)
		else $error("gather header did not arm base word");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(word_s1) && $stable(start_s1))
		else $error("stalled input word lost");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rec.ready |=> valid_s2 && $stable(rec_s2))
		else $error("stalled record changed");

endmodule

`default_nettype wire

>>> hdl/csod_decode.sv
`default_nettype none

module csod_decode (
	input  csod_pkg::state_t  state,
	input  logic [31:0]       command_word,
	input  logic              buffer_start,
	output csod_pkg::record_t record,
	output csod_pkg::state_t  state_next
);
	import csod_pkg::*;

	mode_t       mode_eff;
	logic [3:0]  op;
	logic [11:0] off;
	logic [15:0] low_bit;
	logic [3:0]  low_idx;

	assign op  = command_word[31:28];
	assign off = command_word[27:16];

	// lowest remaining mask bit
	assign low_bit = state.mask_left & (~state.mask_left + 16'd1);

	always_comb begin
		low_idx = 4'd0;
		for (int i = 15; i >= 0; i--) begin
			if (state.mask_left[i]) begin
				low_idx = 4'(i);
			end
		end
	end

	always_comb begin
		record     = '0;
		state_next = state;
		mode_eff   = buffer_start ? MODE_HEADER : state.mode;
		unique case (mode_eff)
			MODE_HEADER: begin
				record.record_kind      = KIND_HEADER;
				record.opcode           = op;
				state_next.owner_opcode = op;
				state_next.reg_pointer  = off;
				state_next.mode         = MODE_HEADER;
				unique case (op) inside
					OPC_SETCL: begin
						record.reg_offset    = off;
						record.class_id      = command_word[15:6];
						record.write_mask    = {10'd0, command_word[5:0]};
						state_next.mask_left = {10'd0, command_word[5:0]};
						if (command_word[5:0] != 6'd0) begin
							state_next.mode = MODE_MASKED;
						end
					end
					OPC_INCR, OPC_NONINCR: begin
						record.reg_offset     = off;
						record.word_count     = command_word[15:0];
						state_next.words_left = command_word[15:0];
						if (command_word[15:0] != 16'd0) begin
							state_next.mode = MODE_COUNT;
						end
					end
					OPC_MASK: begin
						record.reg_offset    = off;
						record.write_mask    = command_word[15:0];
						state_next.mask_left = command_word[15:0];
						if (command_word[15:0] != 16'd0) begin
							state_next.mode = MODE_MASKED;
						end
					end
					OPC_IMM: begin
						record.reg_offset = off;
						record.data_value = {16'd0, command_word[15:0]};
					end
					OPC_RESTART: begin
						record.data_value = {command_word[27:0], 4'd0};
					end
					OPC_GATHER: begin
						record.reg_offset = off;
						record.word_count = {2'd0, command_word[13:0]};
						if (command_word[15]) begin
							record.gather_mode = command_word[14] ? GATHER_INCR
								: GATHER_NONINCR;
						end else begin
							record.gather_mode = GATHER_PLAIN;
						end
						state_next.mode = MODE_GBASE;
					end
					OPC_EXTEND: begin
						record.data_value   = {8'd0, command_word[23:0]};
						record.extend_subop = command_word[27:24];
					end
					OPC_CHDONE: begin
					end
					default: begin
						record.record_kind = KIND_UNKNOWN;
					end
				endcase
			end
			MODE_COUNT: begin
				record.record_kind    = KIND_WRITE;
				record.opcode         = state.owner_opcode;
				record.data_value     = command_word;
				record.reg_offset     = state.reg_pointer;
				if (state.owner_opcode == OPC_INCR) begin
					state_next.reg_pointer = state.reg_pointer + 12'd1;
				end
				state_next.words_left = state.words_left - 16'd1;
				if (state.words_left == 16'd1) begin
					state_next.mode = MODE_HEADER;
				end
			end
			MODE_MASKED: begin
				record.record_kind   = KIND_WRITE;
				record.opcode        = state.owner_opcode;
				record.data_value    = command_word;
				record.reg_offset    = state.reg_pointer + {8'd0, low_idx};
				state_next.mask_left = state.mask_left & ~low_bit;
				if ((state.mask_left & ~low_bit) == 16'd0) begin
					state_next.mode = MODE_HEADER;
				end
			end
			default: begin
				record.record_kind = KIND_GBASE;
				record.opcode      = OPC_GATHER;
				record.data_value  = command_word;
				record.reg_offset  = state.reg_pointer;
				state_next.mode    = MODE_HEADER;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> tb/csod_decode_check.sv
`default_nettype none

module csod_decode_check (
	input  logic clk,
	input  logic arst_n,
	csod_cmd_if  cmd,
	csod_rec_if  rec,
	output int   mismatches,
	output int   records_due
);
	import csod_pkg::*;

	mode_t       parse_mode;
	logic [11:0] target;
	logic [15:0] words_rem;
	logic [15:0] mask_rem;
	logic [3:0]  owner_op;

	record_t expected_records[$];
	int      error_total;
	int      due_total;

	assign mismatches  = error_total;
	assign records_due = due_total;

	function automatic record_t decode_word(input logic [31:0] w, input logic bstart);
		record_t     r;
		logic [3:0]  op;
		logic [11:0] off;
		int          lowest;
		r = '0;
		if (bstart)
			parse_mode = MODE_HEADER;
		if (parse_mode == MODE_HEADER) begin
			op = w[31:28];
			off = w[27:16];
			r.record_kind = KIND_HEADER;
			r.opcode = op;
			owner_op = op;
			target = off;
			case (op)
				OPC_SETCL: begin
					r.reg_offset = off;
					r.class_id = w[15:6];
					r.write_mask = {10'b0, w[5:0]};
					mask_rem = {10'b0, w[5:0]};
					if (mask_rem != 16'd0)
						parse_mode = MODE_MASKED;
				end
				OPC_INCR, OPC_NONINCR: begin
					r.reg_offset = off;
					r.word_count = w[15:0];
					words_rem = w[15:0];
					if (words_rem != 16'd0)
						parse_mode = MODE_COUNT;
				end
				OPC_MASK: begin
					r.reg_offset = off;
					r.write_mask = w[15:0];
					mask_rem = w[15:0];
					if (mask_rem != 16'd0)
						parse_mode = MODE_MASKED;
				end
				OPC_IMM: begin
					r.reg_offset = off;
					r.data_value = {16'b0, w[15:0]};
				end
				OPC_RESTART: begin
					r.data_value = {w[27:0], 4'b0};
				end
				OPC_GATHER: begin
					r.reg_offset = off;
					r.word_count = {2'b0, w[13:0]};
					if (w[15])
						r.gather_mode = w[14] ? GATHER_INCR : GATHER_NONINCR;
					parse_mode = MODE_GBASE;
				end
				OPC_EXTEND: begin
					r.data_value = {8'b0, w[23:0]};
					r.extend_subop = w[27:24];
				end
				OPC_CHDONE: begin
				end
				default: begin
					r.record_kind = KIND_UNKNOWN;
				end
			endcase
		end else begin
			r.record_kind = KIND_WRITE;
			r.opcode = owner_op;
			r.data_value = w;
			case (parse_mode)
				MODE_COUNT: begin
					r.reg_offset = target;
					if (owner_op == OPC_INCR)
						target = target + 12'd1;
					words_rem = words_rem - 16'd1;
					if (words_rem == 16'd0)
						parse_mode = MODE_HEADER;
				end
				MODE_MASKED: begin
					lowest = 0;
					while (lowest < 16 && !mask_rem[lowest])
						lowest++;
					if (lowest < 16)
						mask_rem[lowest] = 1'b0;
					r.reg_offset = target + {8'b0, lowest[3:0]};
					if (mask_rem == 16'd0)
						parse_mode = MODE_HEADER;
				end
				default: begin
					r.record_kind = KIND_GBASE;
					r.opcode = OPC_GATHER;
					r.reg_offset = target;
					parse_mode = MODE_HEADER;
				end
			endcase
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
			error_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		record_t want;
		if (!arst_n) begin
			parse_mode = MODE_HEADER;
			target = '0;
			words_rem = '0;
			mask_rem = '0;
			owner_op = '0;
			expected_records.delete();
			error_total = 0;
			due_total = 0;
		end else begin
			if (rec.valid && rec.ready) begin
				if (expected_records.size() == 0) begin
					$display("%0t record: expected none, actual kind %0d opcode %0h data %0h",
						$time, rec.record_kind, rec.opcode, rec.data_value);
					error_total++;
				end else begin
					want = expected_records.pop_front();
					due_total--;
					compare_field("record_kind", 32'(want.record_kind),
						32'(rec.record_kind));
					compare_field("opcode", 32'(want.opcode), 32'(rec.opcode));
					compare_field("reg_offset", 32'(want.reg_offset), 32'(rec.reg_offset));
					compare_field("class_id", 32'(want.class_id), 32'(rec.class_id));
					compare_field("word_count", 32'(want.word_count), 32'(rec.word_count));
					compare_field("write_mask", 32'(want.write_mask), 32'(rec.write_mask));
					compare_field("data_value", want.data_value, rec.data_value);
					compare_field("gather_mode", 32'(want.gather_mode),
						32'(rec.gather_mode));
					compare_field("extend_subop", 32'(want.extend_subop),
						32'(rec.extend_subop));
				end
			end
			if (cmd.valid && cmd.ready) begin
				expected_records.push_back(decode_word(cmd.command_word, cmd.buffer_start));
				due_total++;
			end
		end
	end

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
	import csod_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 950;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 90;

	typedef struct packed {
		logic [31:0] word;
		logic        start;
	} cmd_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   records_due;
	int   accepted_words = 0;

	cmd_word_t word_queue[$];

	csod_cmd_if cmd_bus ();
	csod_rec_if rec_bus ();

	command_stream_opcode_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rec    (rec_bus)
	);

	csod_decode_check decode_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_bus),
		.rec         (rec_bus),
		.mismatches  (mismatches),
		.records_due (records_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic queue_word(input logic [31:0] w, input logic s);
		word_queue.push_back({w, s});
	endtask

	task automatic queue_directed();
		// set class, offset wraps past 4095
		queue_word({OPC_SETCL, 12'hffe, 10'h3ff, 6'b100101}, 1'b1);
		queue_word(32'hffffffff, 1'b0);
		queue_word(32'h00000000, 1'b0);
		queue_word(32'ha5a5a5a5, 1'b0);
		queue_word({OPC_INCR, 12'hfff, 16'd2}, 1'b0);
		queue_word(32'h12345678, 1'b0);
		queue_word(32'h87654321, 1'b0);
		queue_word({OPC_NONINCR, 12'h123, 16'd1}, 1'b0);
		queue_word(32'hdeadbeef, 1'b0);
		queue_word({OPC_MASK, 12'h800, 16'h8000}, 1'b0);
		queue_word(32'h5a5a5a5a, 1'b0);
		queue_word({OPC_IMM, 12'hfff, 16'hffff}, 1'b0);
		queue_word({OPC_RESTART, 28'hfffffff}, 1'b0);
		queue_word({OPC_GATHER, 12'habc, 2'b11, 14'h3fff}, 1'b0);
		queue_word(32'hcafef00d, 1'b0);
		queue_word({OPC_GATHER, 12'h001, 2'b10, 14'h0000}, 1'b0);
		queue_word(32'h0badf00d, 1'b0);
		queue_word({OPC_EXTEND, 28'hfffffff}, 1'b0);
		queue_word({OPC_CHDONE, 28'h0000000}, 1'b0);
		// unknown opcodes, lowest and highest
		queue_word(32'h7fffffff, 1'b0);
		queue_word(32'hd0000000, 1'b0);
		// empty payloads
		queue_word({OPC_INCR, 12'h010, 16'd0}, 1'b0);
		queue_word({OPC_SETCL, 12'h020, 10'h155, 6'd0}, 1'b0);
		// buffer start drops a pending payload
		queue_word({OPC_INCR, 12'h040, 16'd5}, 1'b0);
		queue_word(32'h11111111, 1'b0);
		queue_word({OPC_IMM, 12'h041, 16'h2222}, 1'b1);
	endtask

	task automatic queue_random(input int count);
		logic [3:0]  op;
		logic [11:0] off;
		logic [15:0] low;
		int          full;
		int          payload;
		int          target;
		bit          restart_next;
		target = word_queue.size() + count;
		restart_next = 1'b1;
		while (word_queue.size() < target) begin
			if ($urandom_range(0, 24) == 0) begin
				queue_word($urandom(), 1'($urandom_range(0, 1)));
				restart_next = 1'b1;
			end else begin
				op = 4'($urandom_range(0, 15));
				if (op > OPC_GATHER && op < OPC_EXTEND && $urandom_range(0, 2) != 0)
					op = 4'($urandom_range(0, 6));
				off = 12'($urandom_range(0, 4095));
				low = 16'($urandom_range(0, 65535));
				full = 0;
				case (op)
					OPC_SETCL: full = $countones(low[5:0]);
					OPC_INCR, OPC_NONINCR: begin
						if ($urandom_range(0, 9) != 0)
							low = 16'($urandom_range(0, 10));
						full = int'(low);
					end
					OPC_MASK: begin
						if ($urandom_range(0, 11) == 0)
							low = 16'd0;
						full = $countones(low);
					end
					OPC_GATHER: full = 1;
					default: full = 0;
				endcase
				payload = full;
				if (full > 10)
					payload = $urandom_range(0, 6);
				else if (full > 0 && $urandom_range(0, 19) == 0)
					payload = $urandom_range(0, full - 1);
				queue_word({op, off, low}, restart_next || $urandom_range(0, 11) == 0);
				repeat (payload)
					queue_word($urandom(), 1'b0);
				restart_next = payload < full;
			end
		end
	endtask

	task automatic send_words();
		cmd_word_t item;
		int        burst_left;
		while (word_queue.size() != 0) begin
			burst_left = $urandom_range(1, 40);
			while (burst_left != 0 && word_queue.size() != 0) begin
				item = word_queue.pop_front();
				cmd_bus.valid <= 1'b1;
				cmd_bus.command_word <= item.word;
				cmd_bus.buffer_start <= item.start;
				do
					@(posedge clk);
				while (cmd_bus.ready !== 1'b1);
				accepted_words++;
				burst_left--;
			end
			if ($urandom_range(0, 2) != 0) begin
				cmd_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 6))
					@(posedge clk);
			end
		end
		cmd_bus.valid <= 1'b0;
	endtask

	initial begin : stimulus
		cmd_bus.valid = 1'b0;
		cmd_bus.command_word = '0;
		cmd_bus.buffer_start = 1'b0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		queue_directed();
		queue_random(RANDOM_WORDS);
		@(posedge clk);
		send_words();
		@(posedge clk);
		wait (records_due == 0);
		repeat (8)
			@(posedge clk);
		if (mismatches == 0)
			$display("command_stream_opcode_decoder: match");
		else
			$display("command_stream_opcode_decoder: mismatch");
		$finish;
	end

	// output side: stall patterns, plus one long hold so the input backs up
	initial begin : receiver
		int pattern;
		int stretch;
		bit held;
		rec_bus.ready = 1'b0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			pattern = $urandom_range(0, 3);
			stretch = $urandom_range(10, 150);
			repeat (stretch) begin
				@(posedge clk);
				if (!held && accepted_words >= HOLD_AFTER) begin
					held = 1'b1;
					rec_bus.ready <= 1'b0;
					repeat (HOLD_CYCLES)
						@(posedge clk);
				end
				case (pattern)
					0: rec_bus.ready <= 1'b1;
					1: rec_bus.ready <= 1'($urandom_range(0, 1));
					2: rec_bus.ready <= $urandom_range(0, 7) == 0;
					default: rec_bus.ready <= $urandom_range(0, 3) != 0;
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (rec_bus.valid && rec_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("command_stream_opcode_decoder: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
hdl/csod_pkg.sv
hdl/csod_cmd_if.sv
hdl/csod_rec_if.sv
hdl/csod_decode.sv
hdl/command_stream_opcode_decoder.sv
tb/csod_decode_check.sv
tb/testbench.sv
